// File: hdl/dcs_pkg.sv
package dcs_pkg;

    // Field widths.
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned LEN_W  = 20;

    // Packet added on the first completion, and the chunk size limit.
    localparam int unsigned PACKET_BYTES = 64;
    localparam int unsigned MAX_CHUNK    = 524288;

    // The chunk limit also saturates at what a length field can hold.
    localparam int unsigned LEN_MAX       = (1 << LEN_W) - 1;
    localparam int unsigned CHUNK_LIMIT_I = (MAX_CHUNK > LEN_MAX) ? LEN_MAX : MAX_CHUNK;
    localparam logic [LEN_W-1:0]  CHUNK_LIMIT = LEN_W'(CHUNK_LIMIT_I);
    localparam logic [ADDR_W-1:0] PACKET_ADD  = ADDR_W'(PACKET_BYTES);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE   = 2'd2;

    localparam logic [ADDR_W-1:0] BUFFER_SIZE_RST = 32'd1048576;

    // Operation codes.
    localparam logic OP_START    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Stream widths.
    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned OUT_DATA_W = 88;
    localparam int unsigned OUT_USER_W = 3;

    // One result item.
    typedef struct packed {
        logic              dma_start;
        logic [ADDR_W-1:0] dma_address;
        logic [LEN_W-1:0]  dma_length;
        logic              finished;
        logic              space_pending;
        logic [ADDR_W-1:0] received_total;
    } result_t;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [ADDR_W-1:0] divisor;
    } mod_req_t;

    // Answer from the shared remainder unit.
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] remainder;
    } mod_rsp_t;

endpackage

// File: hdl/dma_download_chunk_scheduler.sv
// Channel   Direction  Contents
// s_*       in         tuser: operation; tdata: start_pointer, first_chunk, read_pointer
// m_*       out        tuser: dma_start, finished, space_pending;
//                      tdata: dma_address, dma_length, received_total
// cfg_*     in         write enable, register index, 32-bit write data
//
// A start item goes from the idle state straight to the done state. A completion item needs
// one remainder operation by buffer_size (two when the file is not yet complete) on the shared
// bit-serial remainder unit, which passes the value through when buffer_size is zero.
// s_tready is high only while the sequencer is idle; one item is in work at a time.
// A finished result waits in the output register, and the next item is accepted meanwhile.
// Reset clears all control state and loads the configuration reset values.
module dma_download_chunk_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] operation
    input  logic                                s_tuser,
    // [31:0] start_pointer, [51:32] first_chunk, [83:52] read_pointer, [87:84] zero
    input  logic [dcs_pkg::IN_DATA_W-1:0]       s_tdata,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] dma_start, [1] finished, [2] space_pending
    output logic [dcs_pkg::OUT_USER_W-1:0]      m_tuser,
    // [31:0] dma_address, [51:32] dma_length, [83:52] received_total, [87:84] zero
    output logic [dcs_pkg::OUT_DATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcs_pkg::ADDR_W-1:0]          cfg_data
);
    import dcs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADV   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] base_reg, size_reg, file_reg;
    logic [ADDR_W-1:0] total_reg, total_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0]  chunk_reg, chunk_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] rd_reg, rd_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic              in_op;
    logic [ADDR_W-1:0] in_start_ptr;
    logic [LEN_W-1:0]  in_first;
    logic [ADDR_W-1:0] in_rd;
    logic [LEN_W-1:0]  first_sat;
    logic [ADDR_W:0]   sum_wide;
    logic [ADDR_W-1:0] total_sat;
    logic [ADDR_W:0]   reach_wide;
    logic [ADDR_W-1:0] remain;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    dcs_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Unpack the input item.
    assign in_op        = s_tuser;
    assign in_start_ptr = s_tdata[31:0];
    assign in_first     = s_tdata[51:32];
    assign in_rd        = s_tdata[83:52];

    assign first_sat = (in_first > CHUNK_LIMIT) ? CHUNK_LIMIT : in_first;

    // New total with the first-packet bonus, saturating at all ones.
    assign sum_wide  = {1'b0, total_reg} + {{(ADDR_W-LEN_W+1){1'b0}}, chunk_reg}
                     + ((total_reg == '0) ? {1'b0, PACKET_ADD} : '0);
    assign total_sat = sum_wide[ADDR_W] ? '1 : sum_wide[ADDR_W-1:0];

    // Bytes still to come decide the next chunk size.
    assign reach_wide = {1'b0, total_reg} + {{(ADDR_W-LEN_W+1){1'b0}}, CHUNK_LIMIT};
    assign remain     = file_reg - total_reg;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer over the shared remainder unit.
    always_comb
    begin
        state_next       = state_reg;
        total_next       = total_reg;
        wp_next          = wp_reg;
        chunk_next       = chunk_reg;
        pend_next        = pend_reg;
        rd_next          = rd_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        m_valid_next     = m_valid_reg & ~m_tready;
        mod_req.start    = 1'b0;
        mod_req.dividend = wp_reg + {{(ADDR_W-LEN_W){1'b0}}, chunk_reg} - base_reg;
        mod_req.divisor  = size_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rd_next = in_rd;
                    if (in_op == OP_START)
                    begin
                        wp_next    = in_start_ptr;
                        chunk_next = first_sat;
                        total_next = '0;
                        pend_next  = 1'b0;
                        res_next   = '{dma_start: 1'b1, dma_address: in_start_ptr,
                                       dma_length: first_sat, finished: 1'b0,
                                       space_pending: 1'b0, received_total: '0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Advance the write pointer around the ring.
                        total_next    = total_sat;
                        mod_req.start = 1'b1;
                        state_next    = ST_ADV;
                    end
                end
            end
            ST_ADV:
            begin
                if (mod_rsp.done)
                begin
                    wp_next    = mod_rsp.remainder + base_reg;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (total_reg >= file_reg)
                begin
                    total_next = file_reg;
                    pend_next  = 1'b0;
                    res_next   = '{dma_start: 1'b0, dma_address: '0, dma_length: '0,
                                   finished: 1'b1, space_pending: 1'b0,
                                   received_total: file_reg};
                    state_next = ST_DONE;
                end
                else
                begin
                    chunk_next = (reach_wide < {1'b0, file_reg}) ? CHUNK_LIMIT
                                                                 : remain[LEN_W-1:0];
                    // Free space in the ring.
                    mod_req.start    = 1'b1;
                    mod_req.dividend = rd_reg - wp_reg - 32'd1 + size_reg;
                    state_next       = ST_EMPTY;
                end
            end
            ST_EMPTY:
            begin
                if (mod_rsp.done)
                begin
                    if (mod_rsp.remainder >= {{(ADDR_W-LEN_W){1'b0}}, chunk_reg})
                    begin
                        pend_next = 1'b0;
                        res_next  = '{dma_start: 1'b1, dma_address: wp_reg,
                                      dma_length: chunk_reg, finished: 1'b0,
                                      space_pending: 1'b0, received_total: total_reg};
                    end
                    else
                    begin
                        pend_next = 1'b1;
                        res_next  = '{dma_start: 1'b0, dma_address: '0, dma_length: '0,
                                      finished: 1'b0, space_pending: 1'b1,
                                      received_total: total_reg};
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready)
                begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            wp_reg      <= '0;
            chunk_reg   <= '0;
            pend_reg    <= 1'b0;
            base_reg    <= '0;
            size_reg    <= BUFFER_SIZE_RST;
            file_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            wp_reg      <= wp_next;
            chunk_reg   <= chunk_next;
            pend_reg    <= pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BUFFER_BASE: base_reg <= cfg_data;
                    REG_BUFFER_SIZE: size_reg <= cfg_data;
                    REG_FILE_SIZE:   file_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_reg  <= rd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // Pack the result item.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_reg.space_pending, out_reg.finished, out_reg.dma_start};
    assign m_tdata  = {4'b0, out_reg.received_total, out_reg.dma_length,
                       out_reg.dma_address};

endmodule

// File: hdl/dcs_mod_unit.sv
module dcs_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  dcs_pkg::mod_req_t req,
    output dcs_pkg::mod_rsp_t rsp
);
    import dcs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] dvd_reg, dvd_next;
    logic [ADDR_W-1:0] div_reg, div_next;
    logic [ADDR_W:0]   trial;
    logic [ADDR_W:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, dvd_reg[ADDR_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            div_next = req.divisor;
            dvd_next = req.dividend;
            if (req.divisor == '0)
            begin
                // A zero size means plain 32-bit wrap: the value passes through.
                rem_next  = req.dividend;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = '0;
                cnt_next  = 6'(ADDR_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = diff[ADDR_W] ? trial[ADDR_W-1:0] : diff[ADDR_W-1:0];
            dvd_next = {dvd_reg[ADDR_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
